/* rtl/mht_pkg.sv */
// ============================================================================
// mht_pkg
// Shared constants and types for the multi-way modulo hash table: default
// geometry, field widths of the stream transactions and result status codes.
// ============================================================================
package mht_pkg;

  // Default table geometry and stored widths.
  localparam int unsigned DefaultRows       = 1024;
  localparam int unsigned DefaultWays       = 8;
  localparam int unsigned DefaultValueWidth = 16;
  localparam int unsigned DefaultKeyWidth   = 64;

  // Field widths of the request and response transactions.
  localparam int unsigned KeyFieldW    = 64;
  localparam int unsigned ValueFieldW  = 16;
  localparam int unsigned StatusFieldW = 2;
  localparam int unsigned SlotFieldW   = 3;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned InDataW  = KeyFieldW + ValueFieldW;
  localparam int unsigned OutUsedW = ValueFieldW + SlotFieldW;
  localparam int unsigned OutDataW = ((OutUsedW + 7) / 8) * 8;
  localparam int unsigned OutPadW  = OutDataW - OutUsedW;

  // Bits of the key folded into the row index by each step of the modulo unit.
  localparam int unsigned ModChunkW = 16;

  // Request kinds carried in the input tuser bit.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } mht_op_e;

  // Result status codes carried in the output tuser field.
  typedef enum logic [StatusFieldW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_ROW_FULL = 2'd2,
    STATUS_ZERO_KEY = 2'd3
  } mht_status_e;

endpackage

/* rtl/modulo_hash_table_multiway.sv */
// ============================================================================
// modulo_hash_table_multiway
// Set-associative hash table of ROWS rows by WAYS slots. Each row lives in
// one wide word of a key memory and of a value memory; a request reads the
// whole row, compares all ways at once and writes the row back on a successful insert.
// ============================================================================
//
//  Channel   Direction  tdata (low bit first)           tuser
//  --------  ---------  ------------------------------  -----------------
//  s_axis    in         key[63:0], entry_value[15:0]    operation
//  m_axis    out        read_value[15:0], slot[2:0], 0  status[1:0]
//
//  After reset the key memory is cleared one row per cycle through all ROWS
//  rows, during which no request is accepted.
//  With ROWS a power of two a request goes through a row read, then compare
//  and write back. Otherwise the row index is first found by a reciprocal
//  multiplication unit folding in 16 key bits per step, each step a multiply
//  phase and a subtract-and-correct phase, over ceil(KEY_WIDTH/16) steps.
//  A new request is accepted while a response still waits in the output
//  register; the compare cycle holds only when that register stays full.
// ============================================================================
module modulo_hash_table_multiway #(
  parameter int unsigned ROWS        = mht_pkg::DefaultRows,
  parameter int unsigned WAYS        = mht_pkg::DefaultWays,
  parameter int unsigned VALUE_WIDTH = mht_pkg::DefaultValueWidth,
  parameter int unsigned KEY_WIDTH   = mht_pkg::DefaultKeyWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request stream.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [mht_pkg::InDataW-1:0]  s_axis_tdata_i,  // key[63:0], entry_value[79:64]
  input  logic                         s_axis_tuser_i,  // operation[0]
  // Response stream.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [mht_pkg::OutDataW-1:0] m_axis_tdata_o,  // read_value[15:0], slot[18:16]
  output logic [mht_pkg::StatusFieldW-1:0] m_axis_tuser_o // status[1:0]
);

  import mht_pkg::*;

  localparam int unsigned RowW      = $clog2(ROWS);
  localparam int unsigned WayW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam bit          RowsPow2  = ((ROWS & (ROWS - 1)) == 0);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_CMP
  } state_e;

  typedef logic [WAYS-1:0][KEY_WIDTH-1:0]   key_row_t;
  typedef logic [WAYS-1:0][VALUE_WIDTH-1:0] val_row_t;

  // Control and payload registers.
  state_e                   state_q, state_d;
  logic [RowW-1:0]          clr_cnt_q, clr_cnt_d;
  logic [RowW-1:0]          row_q, row_d;
  logic                     op_q, op_d;
  logic [KEY_WIDTH-1:0]     key_q, key_d;
  logic [VALUE_WIDTH-1:0]   val_q, val_d;
  logic                     out_valid_q, out_valid_d;
  mht_status_e              out_status_q, out_status_d;
  logic [ValueFieldW-1:0]   out_value_q, out_value_d;
  logic [SlotFieldW-1:0]    out_slot_q, out_slot_d;

  // Memory ports.
  key_row_t                 key_mem [ROWS];
  val_row_t                 val_mem [ROWS];
  key_row_t                 key_rd_q;
  val_row_t                 val_rd_q;
  logic                     rd_en;
  logic [RowW-1:0]          rd_addr;
  logic                     key_we;
  logic [RowW-1:0]          key_waddr;
  key_row_t                 key_wrow;
  logic                     val_we;

  // Input field views.
  logic [KEY_WIDTH-1:0]     in_key;
  logic [VALUE_WIDTH-1:0]   in_val;
  logic                     in_accept;

  // Compare results.
  logic [WAYS-1:0]          hit_vec;
  logic [WAYS-1:0]          free_vec;
  logic                     found;
  logic [WayW-1:0]          way_idx;
  logic                     way_hit;
  key_row_t                 key_new_row;
  val_row_t                 val_new_row;
  logic [VALUE_WIDTH-1:0]   hit_value;
  logic                     out_free;

  // Modulo unit interface.
  logic                     mod_last;
  logic [RowW-1:0]          mod_rem;

  assign in_key    = KEY_WIDTH'(s_axis_tdata_i[KeyFieldW-1:0]);
  assign in_val    = VALUE_WIDTH'(s_axis_tdata_i[InDataW-1:KeyFieldW]);
  assign in_accept = s_axis_tvalid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || m_axis_tready_i;

  // Row index: the low key bits for a power-of-two row count, otherwise a
  // remainder folded in over key chunks, most significant chunk first.
  if (RowsPow2) begin : g_row_mask
    assign mod_last = 1'b1;
    assign mod_rem  = RowW'(key_q);
  end else begin : g_row_mod
    localparam int unsigned ModSteps = (KEY_WIDTH + ModChunkW - 1) / ModChunkW;
    localparam int unsigned ModKeyW  = ModSteps * ModChunkW;
    localparam int unsigned ModCntW  = (ModSteps > 1) ? $clog2(ModSteps) : 1;
    localparam int unsigned NumW     = 2 * ModChunkW;
    localparam int unsigned QdW      = NumW + ModChunkW;
    localparam logic [NumW-1:0] Recip = NumW'((64'd1 << NumW) / 64'(ROWS));

    logic [ModKeyW-1:0] sr_q;
    logic [RowW-1:0]    rem_q;
    logic [ModCntW-1:0] cnt_q;
    logic               phase_q;
    logic [NumW-1:0]    num_q;
    logic [NumW-1:0]    quot_q;
    logic               mod_run;
    logic [NumW-1:0]    num_d;
    logic [2*NumW-1:0]  prod;
    logic [QdW-1:0]     quot_rows;
    logic [NumW-1:0]    rem_sub;
    logic [NumW-1:0]    rem_fix;

    assign mod_run = (state_q == ST_MOD);

    // First step: the running remainder shifted up by one chunk plus the
    // next chunk, and a quotient estimate that is low by at most one.
    assign num_d = {ModChunkW'(rem_q), sr_q[ModKeyW-1 -: ModChunkW]};
    assign prod  = (2*NumW)'(num_d) * (2*NumW)'(Recip);

    // Second step: subtract the estimated multiple and correct it once.
    assign quot_rows = QdW'(quot_q) * QdW'(ROWS);
    assign rem_sub   = num_q - quot_rows[NumW-1:0];
    assign rem_fix   = (rem_sub >= NumW'(ROWS)) ? (rem_sub - NumW'(ROWS)) : rem_sub;

    assign mod_last = phase_q && (cnt_q == ModCntW'(ModSteps - 1));
    assign mod_rem  = rem_fix[RowW-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_q    <= '0;
        rem_q   <= '0;
        cnt_q   <= '0;
        phase_q <= 1'b0;
        num_q   <= '0;
        quot_q  <= '0;
      end else if (in_accept) begin
        sr_q    <= ModKeyW'(in_key);
        rem_q   <= '0;
        cnt_q   <= '0;
        phase_q <= 1'b0;
      end else if (mod_run) begin
        if (!phase_q) begin
          num_q   <= num_d;
          quot_q  <= prod[2*NumW-1:NumW];
          sr_q    <= sr_q << ModChunkW;
          phase_q <= 1'b1;
        end else begin
          rem_q   <= rem_fix[RowW-1:0];
          cnt_q   <= cnt_q + 1'b1;
          phase_q <= 1'b0;
        end
      end
    end
  end

  // Compare all ways of the row read; the first way that matches or is
  // empty ends the probe, since occupied ways always form a prefix.
  always_comb begin
    found   = 1'b0;
    way_idx = '0;
    for (int w = 0; w < int'(WAYS); w++) begin
      hit_vec[w]  = (key_rd_q[w] == key_q);
      free_vec[w] = (key_rd_q[w] == '0);
    end
    for (int w = int'(WAYS) - 1; w >= 0; w--) begin
      if (hit_vec[w] || free_vec[w]) begin
        found   = 1'b1;
        way_idx = WayW'(w);
      end
    end
  end

  assign way_hit   = found && hit_vec[way_idx];
  assign hit_value = val_rd_q[way_idx];

  // Row images for write back with the selected way replaced.
  always_comb begin
    key_new_row          = key_rd_q;
    val_new_row          = val_rd_q;
    key_new_row[way_idx] = key_q;
    val_new_row[way_idx] = val_q;
  end

  // Sequencer: clearing pass, accept, row index, compare and write back.
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    row_d        = row_q;
    op_d         = op_q;
    key_d        = key_q;
    val_d        = val_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_slot_d   = out_slot_q;
    rd_en        = 1'b0;
    rd_addr      = row_q;
    key_we       = 1'b0;
    key_waddr    = row_q;
    key_wrow     = key_new_row;
    val_we       = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_cnt_q;
        key_wrow  = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == RowW'(ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          op_d  = s_axis_tuser_i;
          key_d = in_key;
          val_d = in_val;
          if (RowsPow2) begin
            rd_en   = 1'b1;
            rd_addr = RowW'(in_key);
            row_d   = RowW'(in_key);
            state_d = ST_CMP;
          end else begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_last) begin
          rd_en   = 1'b1;
          rd_addr = mod_rem;
          row_d   = mod_rem;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_slot_d   = '0;
          out_status_d = STATUS_OK;
          state_d      = ST_IDLE;
          if (key_q == '0) begin
            out_status_d = STATUS_ZERO_KEY;
          end else if (op_q == OP_INSERT) begin
            if (found) begin
              key_we     = 1'b1;
              val_we     = 1'b1;
              out_slot_d = SlotFieldW'(way_idx);
            end else begin
              out_status_d = STATUS_ROW_FULL;
            end
          end else begin
            if (way_hit) begin
              out_value_d = ValueFieldW'(hit_value);
              out_slot_d  = SlotFieldW'(way_idx);
            end else begin
              out_status_d = STATUS_NOT_FOUND;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      row_q        <= '0;
      op_q         <= 1'b0;
      key_q        <= '0;
      val_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_OK;
      out_value_q  <= '0;
      out_slot_q   <= '0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      row_q        <= row_d;
      op_q         <= op_d;
      key_q        <= key_d;
      val_q        <= val_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_slot_q   <= out_slot_d;
    end
  end

  // Key memory: one row write and one registered row read per cycle.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wrow;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr];
    end
  end

  // Value memory: written only together with its key.
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[row_q] <= val_new_row;
    end
    if (rd_en) begin
      val_rd_q <= val_mem[rd_addr];
    end
  end

  // Stream outputs.
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OutPadW{1'b0}}, out_slot_q, out_value_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule
